// ===== sv/ttip_pkg.sv =====
// ----------------------------------------------------------------------------
// ttip_pkg
// shared types, constants and functions of the text to integer parser
// ----------------------------------------------------------------------------
package ttip_pkg;

    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 4;
    localparam int OFFSET_W = 13;

    typedef enum logic [3:0] {
        PH_BEGIN   = 4'd0,
        PH_USTART  = 4'd1,
        PH_SAWM    = 4'd2,
        PH_AFTERM1 = 4'd3,
        PH_ZERO1   = 4'd4,
        PH_ZEROX   = 4'd5,
        PH_ZEROB   = 4'd6,
        PH_DIGITS  = 4'd7,
        PH_STOPPED = 4'd8,
        PH_ERROR   = 4'd9
    } phase_t;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_EMPTY      = 4'd1;
    localparam logic [3:0] ST_JUNK       = 4'd2;
    localparam logic [3:0] ST_OVF        = 4'd3;
    localparam logic [3:0] ST_BAD_FIRST  = 4'd4;
    localparam logic [3:0] ST_BAD_DIGIT  = 4'd9;
    localparam logic [3:0] ST_UNDER      = 4'd14;
    localparam logic [3:0] ST_SOVF       = 4'd15;

    localparam logic [1:0] REG_BASE     = 2'd0;
    localparam logic [1:0] REG_TRAILING = 2'd1;
    localparam logic [1:0] REG_SIGNED   = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;

    localparam logic [7:0] NO_DIGIT = 8'hff;

    // digit value of a character, NO_DIGIT when it is none
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = NO_DIGIT;
        if (c >= 8'h20 && c <= 8'h7e)
        begin
            if (c >= 8'h30 && c <= 8'h39)
                d = c - 8'h30;
            else if (c >= 8'h61)
                d = c - 8'h61 + 8'd10;
            else if (c >= 8'h41)
                d = c - 8'h41 + 8'd10;
        end
        return d;
    endfunction

    function automatic logic [3:0] base_code(input logic [5:0] b, input logic [3:0] first);
        logic [3:0] r;
        case (b)
            6'd2:    r = first;
            6'd8:    r = first + 4'd1;
            6'd10:   r = first + 4'd2;
            6'd16:   r = first + 4'd3;
            default: r = first + 4'd4;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/text_to_integer_parser_top.sv =====
// ----------------------------------------------------------------------------
// text_to_integer_parser_top
// streaming strtoul style parser with base prefixes and signed mode
// ----------------------------------------------------------------------------
// a byte that carries a digit is taken, then multiplied by the base by shift-add,
// one of 6 base bits per cycle through one shared 70-bit adder, and the digit is
// added; other bytes are only taken, and the end of a string passes a finish state
// result registered; the next request is taken while it waits to be taken
// rst_n clears registers to base 0, no trailing text, unsigned, start of string
module text_to_integer_parser_top #(
    parameter int MAX_LEN = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // last
    input  logic        s_tuser,   // empty_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // value[63:0], status[67:64], trailing_offset[80:68]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_FINISH
    } seq_t;

    seq_t               seq_reg;
    logic [5:0]         base_sel_reg;
    logic               trail_reg;
    logic               signed_reg;

    ttip_pkg::phase_t   phase_reg;
    logic [63:0]        acc_reg;
    logic [POS_W-1:0]   pos_reg, dstart_reg, stop_reg;
    logic [5:0]         ebase_reg;
    logic [3:0]         err_reg;
    logic               neg_reg;

    // multiply state: product accumulates, bit index walks the base
    logic [69:0]        prod_reg;
    logic [2:0]         mbit_reg;
    logic [7:0]         mdig_reg;
    logic               end_pending_reg;

    logic [63:0]        out_value_reg;
    logic [3:0]         out_status_reg;
    logic [12:0]        out_off_reg;
    logic               out_valid_reg;

    assign s_tready = (seq_reg == S_IDLE) ? 1'b1 : 1'b0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_off_reg, out_status_reg, out_value_reg};

    wire        acc_in = s_tvalid && s_tready;
    wire [7:0]  c      = s_tdata;
    wire [7:0]  dig    = ttip_pkg::digit_of(c);
    wire [5:0]  clamp_base = (base_sel_reg > 6'd36) ? 6'd36 : base_sel_reg;
    wire [3:0]  first_bad  = ttip_pkg::base_code(base_sel_reg, ttip_pkg::ST_BAD_FIRST);
    wire [POS_W-1:0] pos_inc = (pos_reg < POS_W'(MAX_LEN)) ? pos_reg + 1'b1 : pos_reg;

    // one step of shift-add: product += acc << bit when that base bit is set
    wire [69:0] addend  = ebase_reg[mbit_reg] ? ({6'd0, acc_reg} << mbit_reg) : 70'd0;
    wire [69:0] prod_nx = prod_reg + addend;

    // finish logic
    logic [3:0]  f_st;
    logic [63:0] f_v;
    logic [POS_W-1:0] f_off;

    always_comb
    begin
        f_st  = ttip_pkg::ST_OK;
        f_v   = acc_reg;
        f_off = pos_reg;
        case (phase_reg)
            ttip_pkg::PH_BEGIN, ttip_pkg::PH_USTART:
                f_st = ttip_pkg::ST_EMPTY;
            ttip_pkg::PH_SAWM:
                f_st = first_bad;
            ttip_pkg::PH_AFTERM1:
            begin
                f_v   = '1;
                f_off = stop_reg;
                if (!trail_reg && pos_reg > stop_reg)
                    f_st = ttip_pkg::ST_JUNK;
            end
            ttip_pkg::PH_ZERO1, ttip_pkg::PH_DIGITS:
                if (pos_reg == dstart_reg)
                    f_st = first_bad;
            ttip_pkg::PH_ZEROX, ttip_pkg::PH_ZEROB:
            begin
                f_v   = 64'd0;
                f_off = stop_reg;
                if (!trail_reg)
                    f_st = ttip_pkg::base_code(6'd10, ttip_pkg::ST_BAD_DIGIT);
            end
            ttip_pkg::PH_STOPPED:
            begin
                f_off = stop_reg;
                if (!trail_reg)
                    f_st = ttip_pkg::base_code(ebase_reg, ttip_pkg::ST_BAD_DIGIT);
            end
            default:
                f_st = err_reg;
        endcase
        if (f_st == ttip_pkg::ST_OK && signed_reg)
        begin
            if (neg_reg)
            begin
                if (f_v > 64'h8000_0000_0000_0000)
                    f_st = ttip_pkg::ST_UNDER;
                else
                    f_v = 64'd0 - f_v;
            end
            else if (f_v[63])
                f_st = ttip_pkg::ST_SOVF;
        end
        if (f_st != ttip_pkg::ST_OK)
        begin
            f_v   = 64'd0;
            f_off = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= S_IDLE;
            base_sel_reg    <= 6'd0;
            trail_reg       <= 1'b0;
            signed_reg      <= 1'b0;
            phase_reg       <= ttip_pkg::PH_BEGIN;
            acc_reg         <= 64'd0;
            pos_reg         <= '0;
            dstart_reg      <= '0;
            stop_reg        <= '0;
            ebase_reg       <= 6'd10;
            err_reg         <= 4'd0;
            neg_reg         <= 1'b0;
            prod_reg        <= 70'd0;
            mbit_reg        <= 3'd0;
            mdig_reg        <= 8'd0;
            end_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_value_reg   <= 64'd0;
            out_status_reg  <= 4'd0;
            out_off_reg     <= 13'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ttip_pkg::REG_BASE:     base_sel_reg <= cfg_data;
                    ttip_pkg::REG_TRAILING: trail_reg    <= cfg_data[0];
                    ttip_pkg::REG_SIGNED:   signed_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            case (seq_reg)
                S_IDLE:
                begin
                    if (acc_in)
                    begin
                        logic       want_digit;
                        logic [5:0] base_n;
                        want_digit = 1'b0;
                        base_n     = ebase_reg;
                        end_pending_reg <= s_tlast;
                        if (s_tuser)
                            seq_reg <= S_FINISH;
                        else
                        begin
                            pos_reg <= pos_inc;
                            case (phase_reg)
                                ttip_pkg::PH_BEGIN, ttip_pkg::PH_USTART:
                                begin
                                    if (phase_reg == ttip_pkg::PH_BEGIN && signed_reg
                                        && c == ttip_pkg::CH_MINUS)
                                    begin
                                        neg_reg   <= 1'b1;
                                        phase_reg <= ttip_pkg::PH_USTART;
                                    end
                                    else
                                    begin
                                        dstart_reg <= pos_reg;
                                        acc_reg    <= 64'd0;
                                        if (c == ttip_pkg::CH_MINUS)
                                            phase_reg <= ttip_pkg::PH_SAWM;
                                        else if (base_sel_reg == 6'd0 && c == ttip_pkg::CH_ZERO)
                                        begin
                                            ebase_reg <= 6'd8;
                                            phase_reg <= ttip_pkg::PH_ZERO1;
                                        end
                                        else
                                        begin
                                            base_n = (base_sel_reg == 6'd0) ? 6'd10 : clamp_base;
                                            ebase_reg  <= base_n;
                                            phase_reg  <= ttip_pkg::PH_DIGITS;
                                            if ({2'b00, base_n} > dig)
                                                want_digit = 1'b1;
                                            else
                                            begin
                                                err_reg   <= first_bad;
                                                phase_reg <= ttip_pkg::PH_ERROR;
                                            end
                                        end
                                    end
                                end
                                ttip_pkg::PH_SAWM:
                                begin
                                    if (c == ttip_pkg::CH_ONE)
                                    begin
                                        phase_reg <= ttip_pkg::PH_AFTERM1;
                                        stop_reg  <= pos_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        err_reg   <= first_bad;
                                        phase_reg <= ttip_pkg::PH_ERROR;
                                    end
                                end
                                ttip_pkg::PH_ZERO1:
                                begin
                                    if (c == ttip_pkg::CH_LX || c == ttip_pkg::CH_UX)
                                    begin
                                        stop_reg  <= pos_reg;
                                        phase_reg <= ttip_pkg::PH_ZEROX;
                                    end
                                    else if (c == ttip_pkg::CH_LB || c == ttip_pkg::CH_UB)
                                    begin
                                        stop_reg  <= pos_reg;
                                        phase_reg <= ttip_pkg::PH_ZEROB;
                                    end
                                    else
                                    begin
                                        phase_reg <= ttip_pkg::PH_DIGITS;
                                        if ({2'b00, ebase_reg} > dig)
                                            want_digit = 1'b1;
                                        else if (pos_reg == dstart_reg)
                                        begin
                                            err_reg   <= first_bad;
                                            phase_reg <= ttip_pkg::PH_ERROR;
                                        end
                                        else
                                        begin
                                            stop_reg  <= pos_reg;
                                            phase_reg <= ttip_pkg::PH_STOPPED;
                                        end
                                    end
                                end
                                ttip_pkg::PH_ZEROX, ttip_pkg::PH_ZEROB:
                                begin
                                    acc_reg <= 64'd0;
                                    if ((phase_reg == ttip_pkg::PH_ZEROX && dig < 8'd16) ||
                                        (phase_reg == ttip_pkg::PH_ZEROB &&
                                         (c == ttip_pkg::CH_ZERO || c == ttip_pkg::CH_ONE)))
                                    begin
                                        base_n = (phase_reg == ttip_pkg::PH_ZEROX) ? 6'd16 : 6'd2;
                                        ebase_reg  <= base_n;
                                        dstart_reg <= pos_reg;
                                        phase_reg  <= ttip_pkg::PH_DIGITS;
                                        want_digit = 1'b1;
                                    end
                                    else
                                    begin
                                        ebase_reg <= 6'd10;
                                        phase_reg <= ttip_pkg::PH_STOPPED;
                                    end
                                end
                                ttip_pkg::PH_DIGITS:
                                begin
                                    if ({2'b00, ebase_reg} > dig)
                                        want_digit = 1'b1;
                                    else if (pos_reg == dstart_reg)
                                    begin
                                        err_reg   <= first_bad;
                                        phase_reg <= ttip_pkg::PH_ERROR;
                                    end
                                    else
                                    begin
                                        stop_reg  <= pos_reg;
                                        phase_reg <= ttip_pkg::PH_STOPPED;
                                    end
                                end
                                default: ;
                            endcase
                            if (want_digit)
                            begin
                                // prefix bytes leave the accumulator at zero
                                if (phase_reg != ttip_pkg::PH_DIGITS && phase_reg != ttip_pkg::PH_ZERO1)
                                    acc_reg <= 64'd0;
                                ebase_reg <= base_n;
                                prod_reg  <= 70'd0;
                                mbit_reg  <= 3'd0;
                                mdig_reg  <= dig;
                                seq_reg   <= S_MUL;
                            end
                            else if (s_tlast)
                                seq_reg <= S_FINISH;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg <= prod_nx;
                    mbit_reg <= mbit_reg + 3'd1;
                    if (mbit_reg == 3'd5)
                    begin
                        // last base bit: check overflow, then add the digit
                        if (prod_nx[69:64] != 6'd0 ||
                            ({6'd0, prod_nx[63:0]} + {62'd0, mdig_reg}) > 70'hFFFF_FFFF_FFFF_FFFF)
                        begin
                            err_reg   <= ttip_pkg::ST_OVF;
                            phase_reg <= ttip_pkg::PH_ERROR;
                        end
                        else
                            acc_reg <= prod_nx[63:0] + {56'd0, mdig_reg};
                        seq_reg <= end_pending_reg ? S_FINISH : S_IDLE;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= f_v;
                        out_status_reg <= f_st;
                        out_off_reg    <= 13'(f_off);
                        phase_reg      <= ttip_pkg::PH_BEGIN;
                        acc_reg        <= 64'd0;
                        pos_reg        <= '0;
                        dstart_reg     <= '0;
                        ebase_reg      <= 6'd10;
                        stop_reg       <= '0;
                        err_reg        <= 4'd0;
                        neg_reg        <= 1'b0;
                        seq_reg        <= S_IDLE;
                    end
                end
                default: seq_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != S_IDLE |-> !s_tready) else $error("request taken while busy");
    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == S_MUL |-> mbit_reg <= 3'd5) else $error("multiply ran long");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_status_reg != ttip_pkg::ST_OK |->
        out_value_reg == 64'd0 && out_off_reg == 13'd0) else $error("error result not cleared");
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_LEN)) else $error("position past limit");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream test of the text to integer parser: strings of random and directed
// text go in byte by byte, a behavioural predictor forms the expected value,
// status and trailing offset per string, and a scoreboard checks each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
    logic [63:0] value;
    logic [3:0]  status;
    logic [12:0] offset;
} parse_res_t;

class parse_scoreboard;
    parse_res_t pending[$];
    int errors;

    // per-string state and registers
    logic [5:0]  base_sel;
    logic        trail_ok;
    logic        sgn;
    ttip_pkg::phase_t phase;
    logic [63:0] acc;
    int          pos;
    int          dstart;
    int          stop_pos;
    logic [5:0]  eff_base;
    logic [3:0]  err;
    logic        neg;

    function new();
        errors = 0;
        base_sel = 6'd0;
        trail_ok = 1'b0;
        sgn = 1'b0;
        clear_string();
    endfunction

    function void clear_string();
        phase = ttip_pkg::PH_BEGIN;
        acc = '0;
        pos = 0;
        dstart = 0;
        stop_pos = 0;
        eff_base = 6'd10;
        err = ttip_pkg::ST_OK;
        neg = 1'b0;
    endfunction

    function int char_digit(logic [7:0] c);
        if (c < 8'h20 || c > 8'h7e) return 255;
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a") return c - "a" + 10;
        if (c >= "A") return c - "A" + 10;
        return 255;
    endfunction

    function logic [3:0] status_for_base(logic [5:0] b, logic [3:0] first);
        case (b)
            6'd2:    return first;
            6'd8:    return first + 4'd1;
            6'd10:   return first + 4'd2;
            6'd16:   return first + 4'd3;
            default: return first + 4'd4;
        endcase
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] d);
        case (idx)
            ttip_pkg::REG_BASE:     base_sel = d;
            ttip_pkg::REG_TRAILING: trail_ok = d[0];
            ttip_pkg::REG_SIGNED:   sgn = d[0];
            default: ;
        endcase
    endfunction

    function void fail_with(logic [3:0] code);
        err = code;
        phase = ttip_pkg::PH_ERROR;
    endfunction

    function void add_digit(logic [7:0] c);
        int d;
        logic [127:0] prod;
        d = char_digit(c);
        if (d >= eff_base) begin
            if (pos == dstart) fail_with(status_for_base(base_sel, ttip_pkg::ST_BAD_FIRST));
            else
            begin
                stop_pos = pos;
                phase = ttip_pkg::PH_STOPPED;
            end
            return;
        end
        prod = acc * eff_base + d;
        if (prod[127:64] != 0) begin
            fail_with(ttip_pkg::ST_OVF);
            return;
        end
        acc = prod[63:0];
    endfunction

    function void number_start(logic [7:0] c);
        dstart = pos;
        acc = '0;
        if (c == ttip_pkg::CH_MINUS) phase = ttip_pkg::PH_SAWM;
        else if (base_sel == 6'd0)
        begin
            if (c == ttip_pkg::CH_ZERO)
            begin
                eff_base = 6'd8;
                phase = ttip_pkg::PH_ZERO1;
            end
            else
            begin
                eff_base = 6'd10;
                phase = ttip_pkg::PH_DIGITS;
                add_digit(c);
            end
        end
        else
        begin
            eff_base = base_sel > 6'd36 ? 6'd36 : base_sel;
            phase = ttip_pkg::PH_DIGITS;
            add_digit(c);
        end
    endfunction

    function void take_char(logic [7:0] c);
        logic ok;
        case (phase)
            ttip_pkg::PH_BEGIN:
                if (sgn && c == ttip_pkg::CH_MINUS)
                begin
                    neg = 1'b1;
                    phase = ttip_pkg::PH_USTART;
                end
                else number_start(c);
            ttip_pkg::PH_USTART: number_start(c);
            ttip_pkg::PH_SAWM:
                if (c == ttip_pkg::CH_ONE)
                begin
                    phase = ttip_pkg::PH_AFTERM1;
                    stop_pos = pos + 1;
                end
                else fail_with(status_for_base(base_sel, ttip_pkg::ST_BAD_FIRST));
            ttip_pkg::PH_ZERO1:
                if (c == ttip_pkg::CH_LX || c == ttip_pkg::CH_UX)
                begin
                    stop_pos = pos;
                    phase = ttip_pkg::PH_ZEROX;
                end
                else if (c == ttip_pkg::CH_LB || c == ttip_pkg::CH_UB)
                begin
                    stop_pos = pos;
                    phase = ttip_pkg::PH_ZEROB;
                end
                else
                begin
                    phase = ttip_pkg::PH_DIGITS;
                    add_digit(c);
                end
            ttip_pkg::PH_ZEROX, ttip_pkg::PH_ZEROB:
            begin
                ok = (phase == ttip_pkg::PH_ZEROX) ? (char_digit(c) < 16) :
                     (c == ttip_pkg::CH_ZERO || c == ttip_pkg::CH_ONE);
                acc = '0;
                if (ok)
                begin
                    eff_base = (phase == ttip_pkg::PH_ZEROX) ? 6'd16 : 6'd2;
                    dstart = pos;
                    phase = ttip_pkg::PH_DIGITS;
                    add_digit(c);
                end
                else
                begin
                    eff_base = 6'd10;
                    phase = ttip_pkg::PH_STOPPED;
                end
            end
            ttip_pkg::PH_DIGITS: add_digit(c);
            default: ;
        endcase
        if (pos < 4096) pos++;
    endfunction

    function parse_res_t form_result();
        parse_res_t r;
        r.status = ttip_pkg::ST_OK;
        r.value = acc;
        r.offset = pos[12:0];
        case (phase)
            ttip_pkg::PH_BEGIN, ttip_pkg::PH_USTART: r.status = ttip_pkg::ST_EMPTY;
            ttip_pkg::PH_SAWM: r.status = status_for_base(base_sel, ttip_pkg::ST_BAD_FIRST);
            ttip_pkg::PH_AFTERM1:
            begin
                r.value = '1;
                r.offset = stop_pos[12:0];
                if (!trail_ok && pos > stop_pos) r.status = ttip_pkg::ST_JUNK;
            end
            ttip_pkg::PH_ZERO1, ttip_pkg::PH_DIGITS:
                if (pos == dstart)
                    r.status = status_for_base(base_sel, ttip_pkg::ST_BAD_FIRST);
            ttip_pkg::PH_ZEROX, ttip_pkg::PH_ZEROB:
            begin
                r.value = '0;
                r.offset = stop_pos[12:0];
                if (!trail_ok) r.status = status_for_base(6'd10, ttip_pkg::ST_BAD_DIGIT);
            end
            ttip_pkg::PH_STOPPED:
            begin
                r.offset = stop_pos[12:0];
                if (!trail_ok) r.status = status_for_base(eff_base, ttip_pkg::ST_BAD_DIGIT);
            end
            default: r.status = err;
        endcase
        if (r.status == ttip_pkg::ST_OK && sgn)
        begin
            if (neg)
            begin
                if (r.value > 64'h8000_0000_0000_0000) r.status = ttip_pkg::ST_UNDER;
                else r.value = -r.value;
            end
            else if (r.value[63]) r.status = ttip_pkg::ST_SOVF;
        end
        if (r.status != ttip_pkg::ST_OK)
        begin
            r.value = '0;
            r.offset = '0;
        end
        return r;
    endfunction

    function void note_request(logic [7:0] c, logic lst, logic emp);
        if (!emp)
        begin
            take_char(c);
            if (!lst) return;
        end
        pending.push_back(form_result());
        clear_string();
    endfunction

    function void check_result(parse_res_t got);
        parse_res_t exp;
        if (pending.size() == 0)
        begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.value !== exp.value)
        begin
            $error("value expected %h actual %h", exp.value, got.value);
            errors++;
        end
        if (got.status !== exp.status)
        begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            errors++;
        end
        if (got.offset !== exp.offset)
        begin
            $error("trailing_offset expected %0d actual %0d", exp.offset, got.offset);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tlast = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [5:0]  cfg_data = 0;

    parse_scoreboard sb = new();
    int  idle_pct = 28;
    int  sent_items = 0;
    bit  hold_sink = 0;
    bit  sink_held = 0;

    always #1 clk = ~clk;

    text_to_integer_parser_top DUT (.*);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(parse_res_t'({m_tdata[63:0], m_tdata[67:64], m_tdata[80:68]}));

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink && !sink_held)
            begin
                sink_held = 1;
                m_tready <= 0;
                for (k = 0; k < 300; k++) @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_byte(logic [7:0] c, logic lst, logic emp);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= c;
        s_tlast <= lst;
        s_tuser <= emp;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(c, lst, emp);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        int i;
        if (s.len() == 0) send_byte(8'($urandom), 1'($urandom), 1'b1);
        for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, 1'b0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [5:0] d);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, d);
    endtask

    function automatic logic [7:0] rand_char(int b);
        int r;
        int d;
        r = $urandom_range(99);
        if (r < 75)
        begin
            d = $urandom_range((b < 2 || b > 36) ? 35 : b - 1);
            if (d < 10) return 8'("0" + d);
            return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
        end
        if (r < 85) return 8'($urandom_range(8'h20, 8'h7e));
        if (r < 90) return ttip_pkg::CH_MINUS;
        return 8'($urandom);
    endfunction

    task automatic random_string(int b);
        string s;
        string pre;
        int n;
        int i;
        pre = "";
        case ($urandom_range(7))
            0: pre = "0x";
            1: pre = "0X";
            2: pre = "0b";
            3: pre = "-1";
            4: pre = "-";
            5: pre = "0";
            default: ;
        endcase
        if ($urandom_range(3) == 0) pre = {"-", pre};
        n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        s = pre;
        for (i = 0; i < n; i++) s = {s, string'(rand_char(b))};
        if ($urandom_range(15) == 0)
        begin
            for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, 1'b0);
            send_byte(8'($urandom), 1'($urandom), 1'b1);
        end
        else send_text(s);
    endtask

    initial
    begin
        int ph;
        int b;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: prefixes, minus one, overflow edges, empties, junk
        send_text("0");
        send_text("0x1F");
        send_text("0Xg");
        send_text("0b101");
        send_text("0B2");
        send_text("017");
        send_text("09");
        send_text("-1");
        send_text("-12");
        send_text("-1z");
        send_text("18446744073709551615");
        send_text("18446744073709551616");
        send_text("12ab");
        send_text("");
        send_text({8'h80, "1"});
        send_text({"7", 8'hff});
        write_reg(ttip_pkg::REG_SIGNED, 6'd1);
        send_text("-9223372036854775808");
        send_text("-9223372036854775809");
        send_text("9223372036854775807");
        send_text("9223372036854775808");
        send_text("-");
        send_text("--5");
        write_reg(ttip_pkg::REG_TRAILING, 6'd1);
        send_text("42 abc");
        send_text("0x");
        write_reg(ttip_pkg::REG_BASE, 6'd63);
        send_text("zZ9");
        write_reg(ttip_pkg::REG_BASE, 6'd1);
        send_text("001");

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: b = 0;
                1: b = 36;
                2: b = 16;
                3: b = 2;
                4: b = 8;
                5: b = 10;
                6: b = $urandom_range(37, 63);
                default: b = $urandom_range(1, 36);
            endcase
            write_reg(ttip_pkg::REG_BASE, 6'(b));
            write_reg(ttip_pkg::REG_TRAILING, 6'($urandom_range(1)));
            write_reg(ttip_pkg::REG_SIGNED, 6'($urandom_range(1)));
            idle_pct = (ph == 3) ? 0 : 28;
            if (ph == 4) hold_sink = 1;
            while (sent_items < (ph + 1) * 112)
                random_string(b);
        end
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.errors == 0)
            $display("text_to_integer_parser_top test passed");
        else
            $display("text_to_integer_parser_top test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("text_to_integer_parser_top test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ttip_pkg.sv
sv/text_to_integer_parser_top.sv
tb/tb_top.sv
